// File: hw/rtl/fdma_pkg.sv
package fdma_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_CHANNELS = 4;
    localparam int DEF_ADDRESS_BITS = 32;

    // Per-channel register files always hold four entries
    localparam int MAX_CHANNELS = 4;

    // Operation codes
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // Register offsets
    localparam logic [3:0] REG_INIT     = 4'h0;
    localparam logic [3:0] REG_CHAN     = 4'h1;
    localparam logic [3:0] REG_COUNT_LO = 4'h2;
    localparam logic [3:0] REG_COUNT_HI = 4'h3;
    localparam logic [3:0] REG_ADDR_0   = 4'h4;
    localparam logic [3:0] REG_ADDR_1   = 4'h5;
    localparam logic [3:0] REG_ADDR_2   = 4'h6;
    localparam logic [3:0] REG_ADDR_3   = 4'h7;
    localparam logic [3:0] REG_DEV_LO   = 4'h8;
    localparam logic [3:0] REG_DEV_HI   = 4'h9;
    localparam logic [3:0] REG_MODE     = 4'ha;
    localparam logic [3:0] REG_STATUS   = 4'hb;
    localparam logic [3:0] REG_TEMP_LO  = 4'hc;
    localparam logic [3:0] REG_TEMP_HI  = 4'hd;
    localparam logic [3:0] REG_REQUEST  = 4'he;
    localparam logic [3:0] REG_MASK     = 4'hf;

    // Request answer codes
    localparam logic [1:0] CODE_ACCEPTED = 2'd0;
    localparam logic [1:0] CODE_MASKED   = 2'd1;
    localparam logic [1:0] CODE_DISABLED = 2'd2;

    // Mode byte fields
    localparam logic [1:0] DIR_IO_TO_MEM = 2'b01;
    localparam logic [1:0] DIR_MEM_TO_IO = 2'b10;
    localparam logic [1:0] MODE_DEMAND   = 2'b00;
    localparam logic [1:0] MODE_SINGLE   = 2'b01;
    localparam int         MODE_AUTO_BIT = 4;
    localparam int         MODE_DEC_BIT  = 5;

    localparam int         DEV_DISABLE_BIT = 2;
    localparam logic [7:0] MASK_RESET      = 8'h0f;
    localparam logic [15:0] COUNT_WRAP     = 16'hffff;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] reg_offset;
        logic [7:0] reg_wdata;
        logic [1:0] chan;
        logic       request_level;
        logic [7:0] io_in_byte;
        logic [7:0] mem_in_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  reg_rdata;
        logic [1:0]  request_code;
        logic        mem_write_strobe;
        logic        mem_read_strobe;
        logic [31:0] mem_address;
        logic        io_write_strobe;
        logic [7:0]  transfer_byte;
        logic        eop_level;
    } result_t;

    // Channel status seen by the top level
    typedef struct packed {
        logic [MAX_CHANNELS-1:0] line_active;
        logic [MAX_CHANNELS-1:0] request_present;
        logic [MAX_CHANNELS-1:0] pending;
    } chan_status_t;

endpackage

// File: hw/rtl/fdma_in_stage.sv
module fdma_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  fdma_pkg::item_t item_in,
    input  logic            advance,
    output logic            valid,
    output fdma_pkg::item_t item_out
);
    import fdma_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Hold the request until the core takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

// File: hw/rtl/fdma_core.sv
module fdma_core #(
    parameter int NUM_CHANNELS = fdma_pkg::DEF_NUM_CHANNELS,
    parameter int ADDRESS_BITS = fdma_pkg::DEF_ADDRESS_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  fdma_pkg::item_t        item,
    output fdma_pkg::result_t      result,
    output fdma_pkg::chan_status_t status
);
    import fdma_pkg::*;

    localparam int AW = ADDRESS_BITS;

    logic [1:0]  selected_channel_reg, selected_channel_next;
    logic        base_only_reg, base_only_next;
    logic        wide_bus_reg, wide_bus_next;
    logic [15:0] count_base_reg [MAX_CHANNELS];
    logic [15:0] count_base_next [MAX_CHANNELS];
    logic [15:0] count_current_reg [MAX_CHANNELS];
    logic [15:0] count_current_next [MAX_CHANNELS];
    logic [AW-1:0] address_base_reg [MAX_CHANNELS];
    logic [AW-1:0] address_base_next [MAX_CHANNELS];
    logic [AW-1:0] address_current_reg [MAX_CHANNELS];
    logic [AW-1:0] address_current_next [MAX_CHANNELS];
    logic [15:0] device_ctrl_reg, device_ctrl_next;
    logic [7:0]  channel_mode_reg [MAX_CHANNELS];
    logic [7:0]  channel_mode_next [MAX_CHANNELS];
    logic [7:0]  status_bits_reg, status_bits_next;
    logic [7:0]  request_bits_reg, request_bits_next;
    logic [7:0]  mask_bits_reg, mask_bits_next;
    logic [NUM_CHANNELS-1:0] line_active_reg, line_active_next;
    logic [NUM_CHANNELS-1:0] pending_reg, pending_next;
    logic        eop_reg, eop_next;

    logic [NUM_CHANNELS-1:0] chan_onehot;
    logic        chan_ok;
    logic        pend_hit;
    logic [1:0]  c_sel;
    logic [1:0]  ch;
    logic [15:0] cnt_view;
    logic [31:0] addr_view;
    logic [31:0] addr_word;
    logic [15:0] cnt_word;
    logic [7:0]  tick_mode;
    logic [1:0]  tick_dir;
    logic [AW-1:0] addr_step;
    logic [15:0] cnt_step;
    result_t     res;

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            chan_onehot[i] = (item.chan == 2'(i));
        end
    end

    assign chan_ok  = |chan_onehot;
    assign pend_hit = |(pending_reg & chan_onehot);
    assign c_sel    = selected_channel_reg;
    assign ch       = item.chan;
    assign cnt_view = base_only_reg ? count_base_reg[c_sel] : count_current_reg[c_sel];
    assign addr_view = base_only_reg ? 32'(address_base_reg[c_sel])
                                     : 32'(address_current_reg[c_sel]);
    assign tick_mode = channel_mode_reg[ch];
    assign tick_dir  = tick_mode[3:2];
    assign addr_step = tick_mode[MODE_DEC_BIT] ? address_current_reg[ch] - AW'(1)
                                               : address_current_reg[ch] + AW'(1);
    assign cnt_step  = count_current_reg[ch] - 16'd1;

    always_comb
    begin
        selected_channel_next = selected_channel_reg;
        base_only_next        = base_only_reg;
        wide_bus_next         = wide_bus_reg;
        count_base_next       = count_base_reg;
        count_current_next    = count_current_reg;
        address_base_next     = address_base_reg;
        address_current_next  = address_current_reg;
        device_ctrl_next      = device_ctrl_reg;
        channel_mode_next     = channel_mode_reg;
        status_bits_next      = status_bits_reg;
        request_bits_next     = request_bits_reg;
        mask_bits_next        = mask_bits_reg;
        line_active_next      = line_active_reg;
        pending_next          = pending_reg;
        eop_next              = eop_reg;
        addr_word             = 32'(address_base_reg[c_sel]);
        cnt_word              = count_base_reg[c_sel];
        res                   = '0;

        case (item.operation)
            OP_READ:
            begin
                case (item.reg_offset)
                    REG_CHAN:
                    begin
                        res.reg_rdata    = 8'd1 << c_sel;
                        res.reg_rdata[4] = base_only_reg;
                    end
                    REG_COUNT_LO, REG_COUNT_HI:
                        res.reg_rdata = cnt_view[{item.reg_offset[0], 3'b000} +: 8];
                    REG_ADDR_0, REG_ADDR_1, REG_ADDR_2, REG_ADDR_3:
                        res.reg_rdata = addr_view[{item.reg_offset[1:0], 3'b000} +: 8];
                    REG_DEV_LO:  res.reg_rdata = device_ctrl_reg[7:0];
                    REG_DEV_HI:  res.reg_rdata = device_ctrl_reg[15:8];
                    REG_MODE:    res.reg_rdata = channel_mode_reg[c_sel];
                    REG_STATUS:
                    begin
                        res.reg_rdata         = status_bits_reg;
                        status_bits_next[3:0] = 4'd0;
                    end
                    REG_REQUEST: res.reg_rdata = request_bits_reg;
                    REG_MASK:    res.reg_rdata = mask_bits_reg;
                    default:     res.reg_rdata = 8'd0;
                endcase
            end
            OP_WRITE:
            begin
                case (item.reg_offset)
                    REG_INIT:
                    begin
                        wide_bus_next = item.reg_wdata[1];
                        if (item.reg_wdata[0])
                        begin
                            selected_channel_next = 2'd0;
                            base_only_next        = 1'b0;
                            for (int i = 0; i < MAX_CHANNELS; i++)
                            begin
                                channel_mode_next[i] = 8'd0;
                            end
                            device_ctrl_next      = 16'd0;
                            mask_bits_next        = MASK_RESET;
                            status_bits_next[3:0] = 4'd0;
                            request_bits_next     = 8'd0;
                        end
                    end
                    REG_CHAN:
                    begin
                        selected_channel_next = item.reg_wdata[1:0];
                        base_only_next        = item.reg_wdata[2];
                    end
                    REG_COUNT_LO, REG_COUNT_HI:
                    begin
                        cnt_word[{item.reg_offset[0], 3'b000} +: 8] = item.reg_wdata;
                        count_base_next[c_sel] = cnt_word;
                        if (!base_only_reg)
                        begin
                            cnt_word = count_current_reg[c_sel];
                            cnt_word[{item.reg_offset[0], 3'b000} +: 8] = item.reg_wdata;
                            count_current_next[c_sel] = cnt_word;
                        end
                    end
                    REG_ADDR_0, REG_ADDR_1, REG_ADDR_2, REG_ADDR_3:
                    begin
                        addr_word[{item.reg_offset[1:0], 3'b000} +: 8] = item.reg_wdata;
                        address_base_next[c_sel] = addr_word[AW-1:0];
                        if (!base_only_reg)
                        begin
                            addr_word = 32'(address_current_reg[c_sel]);
                            addr_word[{item.reg_offset[1:0], 3'b000} +: 8] = item.reg_wdata;
                            address_current_next[c_sel] = addr_word[AW-1:0];
                        end
                    end
                    REG_DEV_LO:  device_ctrl_next[7:0]   = item.reg_wdata;
                    REG_DEV_HI:  device_ctrl_next[15:8]  = item.reg_wdata;
                    REG_MODE:    channel_mode_next[c_sel] = item.reg_wdata;
                    REG_REQUEST: request_bits_next = item.reg_wdata;
                    REG_MASK:    mask_bits_next    = item.reg_wdata;
                    default:     ;
                endcase
            end
            OP_REQUEST:
            begin
                if (!chan_ok)
                begin
                    res.request_code = item.request_level ? CODE_MASKED : CODE_ACCEPTED;
                end
                else if (item.request_level)
                begin
                    if (device_ctrl_reg[DEV_DISABLE_BIT])
                    begin
                        res.request_code = CODE_DISABLED;
                    end
                    else if (mask_bits_reg[{1'b0, ch}])
                    begin
                        res.request_code = CODE_MASKED;
                    end
                    else
                    begin
                        line_active_next = line_active_reg | chan_onehot;
                        status_bits_next[{1'b1, ch}] = 1'b1;
                        case (channel_mode_reg[ch][7:6])
                            MODE_DEMAND:
                            begin
                                eop_next     = 1'b0;
                                pending_next = pending_reg | chan_onehot;
                            end
                            MODE_SINGLE:
                                pending_next = pending_reg | chan_onehot;
                            default: ;
                        endcase
                    end
                end
                else
                begin
                    line_active_next = line_active_reg & ~chan_onehot;
                    status_bits_next[{1'b1, ch}] = 1'b0;
                    status_bits_next[{1'b0, ch}] = 1'b1;
                end
            end
            default:
            begin
                // Transfer tick: consume the pending transfer, move at most one byte
                if (pend_hit)
                begin
                    pending_next = pending_reg & ~chan_onehot;
                    if (tick_dir == DIR_IO_TO_MEM || tick_dir == DIR_MEM_TO_IO)
                    begin
                        res.mem_address = 32'(address_current_reg[ch]);
                        if (tick_dir == DIR_IO_TO_MEM)
                        begin
                            res.mem_write_strobe = 1'b1;
                            res.transfer_byte    = item.io_in_byte;
                        end
                        else
                        begin
                            res.mem_read_strobe = 1'b1;
                            res.io_write_strobe = 1'b1;
                            res.transfer_byte   = item.mem_in_byte;
                        end
                        address_current_next[ch] = addr_step;
                        count_current_next[ch]   = cnt_step;
                        if (cnt_step == COUNT_WRAP)
                        begin
                            if (tick_mode[MODE_AUTO_BIT])
                            begin
                                address_current_next[ch] = address_base_reg[ch];
                                count_current_next[ch]   = count_base_reg[ch];
                            end
                            eop_next = 1'b1;
                        end
                    end
                end
            end
        endcase

        res.eop_level = eop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            selected_channel_reg <= 2'd0;
            base_only_reg        <= 1'b0;
            wide_bus_reg         <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                count_base_reg[i]      <= 16'd0;
                count_current_reg[i]   <= 16'd0;
                address_base_reg[i]    <= '0;
                address_current_reg[i] <= '0;
                channel_mode_reg[i]    <= 8'd0;
            end
            device_ctrl_reg  <= 16'd0;
            status_bits_reg  <= 8'd0;
            request_bits_reg <= 8'd0;
            mask_bits_reg    <= MASK_RESET;
            line_active_reg  <= '0;
            pending_reg      <= '0;
            eop_reg          <= 1'b0;
        end
        else if (advance)
        begin
            selected_channel_reg <= selected_channel_next;
            base_only_reg        <= base_only_next;
            wide_bus_reg         <= wide_bus_next;
            count_base_reg       <= count_base_next;
            count_current_reg    <= count_current_next;
            address_base_reg     <= address_base_next;
            address_current_reg  <= address_current_next;
            device_ctrl_reg      <= device_ctrl_next;
            channel_mode_reg     <= channel_mode_next;
            status_bits_reg      <= status_bits_next;
            request_bits_reg     <= request_bits_next;
            mask_bits_reg        <= mask_bits_next;
            line_active_reg      <= line_active_next;
            pending_reg          <= pending_next;
            eop_reg              <= eop_next;
        end
    end

    assign result                 = res;
    assign status.line_active     = MAX_CHANNELS'(line_active_reg);
    assign status.request_present = status_bits_reg[7:4];
    assign status.pending         = MAX_CHANNELS'(pending_reg);

endmodule

// File: hw/rtl/fdma_out_stage.sv
module fdma_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  fdma_pkg::result_t result_in,
    input  logic              take,
    output logic              valid,
    output logic              ready,
    output fdma_pkg::result_t result_out
);
    import fdma_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign ready      = !valid_reg || take;
    assign result_out = result_reg;

endmodule

// File: hw/rtl/four_channel_dma_controller.sv
// Four-channel DMA controller, byte-register programming model.
// Slave stream (s_*): one request per beat. s_tuser carries the operation
// (register read, register write, request-line event, transfer tick);
// s_tdata carries the register offset, write byte, channel, request level
// and the I/O and memory bytes.
// Master stream (m_*): exactly one result per request, in order: read data,
// request answer code, memory/I/O strobes, memory address, moved byte and the
// end-of-process level after the request.
// Flow: a request accepted into the input register is processed once the
// result register can take it; its result then enters the result register,
// m_tvalid rises with it, and the receiver takes it while m_tready is high.
// Throughput: one request per cycle while m_tready holds high; the input
// register and the result register each hold one request, and the register
// file updates in the same cycle that a result enters the result register.
// Reset: all registers clear, the mask register comes up with every channel
// masked, and both stream registers empty.
// Stall: while m_tready is low the result is held; one more request is
// taken into the input register, then s_tready drops until the result goes.
module four_channel_dma_controller #(
    parameter int NUM_CHANNELS = fdma_pkg::DEF_NUM_CHANNELS,
    parameter int ADDRESS_BITS = fdma_pkg::DEF_ADDRESS_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] reg_offset, [11:4] reg_wdata, [13:12] chan, [14] request_level,
    // [22:15] io_in_byte, [30:23] mem_in_byte, [31] zero
    input  logic [31:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] reg_rdata, [9:8] request_code, [10] mem_write_strobe,
    // [11] mem_read_strobe, [43:12] mem_address, [44] io_write_strobe,
    // [52:45] transfer_byte, [53] eop_level, [55:54] zero
    output logic [55:0] m_tdata
);
    import fdma_pkg::*;

    item_t        item_in;
    item_t        item_held;
    result_t      result_next;
    result_t      result_out;
    chan_status_t chan_status;
    logic         in_valid;
    logic         out_ready;
    logic         advance;
    logic         load_in;

    // Unpack the incoming request
    assign item_in.operation     = s_tuser;
    assign item_in.reg_offset    = s_tdata[3:0];
    assign item_in.reg_wdata     = s_tdata[11:4];
    assign item_in.chan          = s_tdata[13:12];
    assign item_in.request_level = s_tdata[14];
    assign item_in.io_in_byte    = s_tdata[22:15];
    assign item_in.mem_in_byte   = s_tdata[30:23];

    // Advance the held request whenever the result register can take it
    assign advance  = in_valid && out_ready;
    assign s_tready = !in_valid || advance;
    assign load_in  = s_tvalid && s_tready;

    fdma_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load_in),
        .item_in  (item_in),
        .advance  (advance),
        .valid    (in_valid),
        .item_out (item_held)
    );

    fdma_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_held),
        .result  (result_next),
        .status  (chan_status)
    );

    fdma_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (result_next),
        .take       (m_tready),
        .valid      (m_tvalid),
        .ready      (out_ready),
        .result_out (result_out)
    );

    // Pack the result, first field in the lowest bits
    assign m_tdata = {2'b00,
                      result_out.eop_level,
                      result_out.transfer_byte,
                      result_out.io_write_strobe,
                      result_out.mem_address,
                      result_out.mem_read_strobe,
                      result_out.mem_write_strobe,
                      result_out.request_code,
                      result_out.reg_rdata};

    // A request line is active exactly when its request-present status bit is set
    assert property (@(posedge clk) disable iff (!rst_n)
        chan_status.line_active == chan_status.request_present)
        else $error("line state and request-present status disagree");

    // A request processed at this edge must be offered at the next
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed request lost before the output");

    // An empty result register never blocks a held request
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !m_tvalid) |-> s_tready)
        else $error("input stalled with an empty result register");

    // A transfer moves one byte in one direction only
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!(result_out.mem_write_strobe && result_out.mem_read_strobe)
                      && (result_out.io_write_strobe == result_out.mem_read_strobe)))
        else $error("inconsistent transfer strobes");

endmodule

// File: sim/four_channel_dma_controller_test.sv
module four_channel_dma_controller_test;

    import fdma_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // [3:0] reg_offset, [11:4] reg_wdata, [13:12] chan, [14] request_level,
    // [22:15] io_in_byte, [30:23] mem_in_byte, [31] zero
    logic [31:0] s_tdata;
    // [1:0] operation
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // [7:0] reg_rdata, [9:8] request_code, [10] mem_write_strobe,
    // [11] mem_read_strobe, [43:12] mem_address, [44] io_write_strobe,
    // [52:45] transfer_byte, [53] eop_level, [55:54] zero
    logic [55:0] m_tdata;

    four_channel_dma_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the controller's registers
    logic [1:0]  sel_chan;
    logic        base_view;
    logic        wide_bus_bit;
    logic [15:0] cnt_base [4];
    logic [15:0] cnt_cur [4];
    logic [31:0] addr_base [4];
    logic [31:0] addr_cur [4];
    logic [15:0] dev_ctrl;
    logic [7:0]  chan_mode [4];
    logic [7:0]  status_reg;
    logic [7:0]  request_reg;
    logic [7:0]  mask_reg;
    logic [3:0]  armed;
    logic        eop;

    result_t awaited_results[$];
    int      items_sent = 0;
    int      fail_count = 0;
    bit      sender_idles = 1'b1;
    bit      receiver_idles = 1'b1;
    int      hold_off_request = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void soft_clear();
        sel_chan = 2'd0;
        base_view = 1'b0;
        for (int i = 0; i < 4; i++)
            chan_mode[i] = 8'h00;
        dev_ctrl = 16'h0000;
        mask_reg = MASK_RESET;
        status_reg[3:0] = 4'h0;
        request_reg = 8'h00;
    endfunction

    function automatic void clear_dma_state();
        wide_bus_bit = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            cnt_base[i] = 16'h0000;
            cnt_cur[i] = 16'h0000;
            addr_base[i] = 32'h0;
            addr_cur[i] = 32'h0;
        end
        status_reg = 8'h00;
        armed = 4'h0;
        eop = 1'b0;
        soft_clear();
    endfunction

    // Apply one request to the shadow registers and return the result it gives
    function automatic result_t dma_register_step(input item_t req);
        result_t     res;
        logic [1:0]  c;
        logic [1:0]  ch;
        logic [1:0]  dir;
        logic [7:0]  wb;
        logic [15:0] count_view;
        logic [31:0] addr_view;
        int          sh;
        res = '0;
        c = sel_chan;
        ch = req.chan;
        wb = req.reg_wdata;
        count_view = base_view ? cnt_base[c] : cnt_cur[c];
        addr_view = base_view ? addr_base[c] : addr_cur[c];
        case (req.operation)
            OP_READ:
            begin
                case (req.reg_offset)
                    REG_CHAN:     res.reg_rdata = (8'h01 << c) | (base_view ? 8'h10 : 8'h00);
                    REG_COUNT_LO: res.reg_rdata = count_view[7:0];
                    REG_COUNT_HI: res.reg_rdata = count_view[15:8];
                    REG_ADDR_0, REG_ADDR_1, REG_ADDR_2, REG_ADDR_3:
                        res.reg_rdata = 8'(addr_view >> (8 * int'(req.reg_offset - REG_ADDR_0)));
                    REG_DEV_LO:   res.reg_rdata = dev_ctrl[7:0];
                    REG_DEV_HI:   res.reg_rdata = dev_ctrl[15:8];
                    REG_MODE:     res.reg_rdata = chan_mode[c];
                    REG_STATUS:
                    begin
                        // low status bits, set on release, clear once read
                        res.reg_rdata = status_reg;
                        status_reg[3:0] = 4'h0;
                    end
                    REG_REQUEST:  res.reg_rdata = request_reg;
                    REG_MASK:     res.reg_rdata = mask_reg;
                    default:      res.reg_rdata = 8'h00;
                endcase
            end
            OP_WRITE:
            begin
                case (req.reg_offset)
                    REG_INIT:
                    begin
                        wide_bus_bit = wb[1];
                        if (wb[0])
                            soft_clear();
                    end
                    REG_CHAN:
                    begin
                        sel_chan = wb[1:0];
                        base_view = wb[2];
                    end
                    REG_COUNT_LO, REG_COUNT_HI:
                    begin
                        sh = (req.reg_offset == REG_COUNT_HI) ? 8 : 0;
                        cnt_base[c][sh +: 8] = wb;
                        if (!base_view)
                            cnt_cur[c][sh +: 8] = wb;
                    end
                    REG_ADDR_0, REG_ADDR_1, REG_ADDR_2, REG_ADDR_3:
                    begin
                        sh = 8 * int'(req.reg_offset - REG_ADDR_0);
                        addr_base[c][sh +: 8] = wb;
                        if (!base_view)
                            addr_cur[c][sh +: 8] = wb;
                    end
                    REG_DEV_LO:  dev_ctrl[7:0] = wb;
                    REG_DEV_HI:  dev_ctrl[15:8] = wb;
                    REG_MODE:    chan_mode[c] = wb;
                    REG_REQUEST: request_reg = wb;
                    REG_MASK:    mask_reg = wb;
                    default:     ;
                endcase
            end
            OP_REQUEST:
            begin
                res.request_code = CODE_ACCEPTED;
                if (req.request_level)
                begin
                    if (dev_ctrl[DEV_DISABLE_BIT])
                        res.request_code = CODE_DISABLED;
                    else if (mask_reg[ch])
                        res.request_code = CODE_MASKED;
                    else
                    begin
                        status_reg[4 + ch] = 1'b1;
                        if (chan_mode[ch][7:6] == MODE_DEMAND)
                        begin
                            eop = 1'b0;
                            armed[ch] = 1'b1;
                        end
                        else if (chan_mode[ch][7:6] == MODE_SINGLE)
                            armed[ch] = 1'b1;
                    end
                end
                else
                begin
                    // release counts even on a masked or disabled channel
                    status_reg[4 + ch] = 1'b0;
                    status_reg[ch] = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (armed[ch])
                begin
                    armed[ch] = 1'b0;
                    dir = chan_mode[ch][3:2];
                    if (dir == DIR_IO_TO_MEM || dir == DIR_MEM_TO_IO)
                    begin
                        res.mem_address = addr_cur[ch];
                        if (dir == DIR_IO_TO_MEM)
                        begin
                            res.mem_write_strobe = 1'b1;
                            res.transfer_byte = req.io_in_byte;
                        end
                        else
                        begin
                            res.mem_read_strobe = 1'b1;
                            res.io_write_strobe = 1'b1;
                            res.transfer_byte = req.mem_in_byte;
                        end
                        addr_cur[ch] = chan_mode[ch][MODE_DEC_BIT] ? addr_cur[ch] - 32'd1
                                                                    : addr_cur[ch] + 32'd1;
                        cnt_cur[ch] = cnt_cur[ch] - 16'd1;
                        if (cnt_cur[ch] == COUNT_WRAP)
                        begin
                            if (chan_mode[ch][MODE_AUTO_BIT])
                            begin
                                addr_cur[ch] = addr_base[ch];
                                cnt_cur[ch] = cnt_base[ch];
                            end
                            eop = 1'b1;
                        end
                    end
                end
            end
        endcase
        res.eop_level = eop;
        return res;
    endfunction

    function automatic item_t compose_request(input int op, input int off, input int wb,
                                              input int ch, input int lvl);
        item_t req;
        req = 33'({$urandom, $urandom});
        req.operation = 2'(op);
        req.reg_offset = 4'(off);
        req.reg_wdata = 8'(wb);
        req.chan = 2'(ch);
        req.request_level = 1'(lvl);
        return req;
    endfunction

    // Offer one request at the falling edge, hold it until taken
    task automatic send_request(input item_t req);
        int gap;
        gap = (sender_idles && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req.operation;
        s_tdata <= {1'b0, req.mem_in_byte, req.io_in_byte, req.request_level, req.chan,
                    req.reg_wdata, req.reg_offset};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        awaited_results.push_back(dma_register_step(req));
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Result side: random stall bursts, plus a long hold-off on demand
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request > 0)
            begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("reg_rdata", want.reg_rdata, m_tdata[7:0]);
                check_field("request_code", want.request_code, m_tdata[9:8]);
                check_field("mem_write_strobe", want.mem_write_strobe, m_tdata[10]);
                check_field("mem_read_strobe", want.mem_read_strobe, m_tdata[11]);
                check_field("mem_address", want.mem_address, m_tdata[43:12]);
                check_field("io_write_strobe", want.io_write_strobe, m_tdata[44]);
                check_field("transfer_byte", want.transfer_byte, m_tdata[52:45]);
                check_field("eop_level", want.eop_level, m_tdata[53]);
            end
        end
    end

    // Masking, disabling, terminal count with auto-initialise, both directions,
    // empty and no-move ticks, release, status clear and soft reset
    task automatic test_directed_sequence();
        item_t req;
        send_request(compose_request(OP_READ, REG_MASK, 8'h00, 0, 0));
        send_request(compose_request(OP_REQUEST, REG_INIT, 8'h00, 0, 1));
        send_request(compose_request(OP_WRITE, REG_MASK, 8'h00, 0, 0));
        send_request(compose_request(OP_WRITE, REG_DEV_LO, 8'h04, 0, 0));
        send_request(compose_request(OP_REQUEST, REG_INIT, 8'h00, 1, 1));
        send_request(compose_request(OP_WRITE, REG_DEV_LO, 8'h00, 0, 0));
        send_request(compose_request(OP_WRITE, REG_CHAN, 8'h03, 0, 0));
        send_request(compose_request(OP_WRITE, REG_COUNT_LO, 8'h00, 0, 0));
        send_request(compose_request(OP_WRITE, REG_ADDR_0, 8'hff, 0, 0));
        send_request(compose_request(OP_WRITE, REG_ADDR_1, 8'hff, 0, 0));
        send_request(compose_request(OP_WRITE, REG_ADDR_2, 8'hff, 0, 0));
        send_request(compose_request(OP_WRITE, REG_ADDR_3, 8'hff, 0, 0));
        // demand, I/O to memory, auto-initialise, count already at zero
        send_request(compose_request(OP_WRITE, REG_MODE, 8'h14, 0, 0));
        send_request(compose_request(OP_REQUEST, REG_INIT, 8'h00, 3, 1));
        req = compose_request(OP_TICK, REG_INIT, 8'h00, 3, 0);
        req.io_in_byte = 8'hff;
        req.mem_in_byte = 8'h00;
        send_request(req);
        send_request(compose_request(OP_TICK, REG_INIT, 8'h00, 3, 0));
        // single, memory to I/O, decrementing, no auto-initialise
        send_request(compose_request(OP_WRITE, REG_MODE, 8'h68, 0, 0));
        send_request(compose_request(OP_REQUEST, REG_INIT, 8'h00, 3, 1));
        req = compose_request(OP_TICK, REG_INIT, 8'h00, 3, 0);
        req.io_in_byte = 8'h00;
        req.mem_in_byte = 8'hff;
        send_request(req);
        // invalid direction: tick consumed, nothing moves; demand clears eop
        send_request(compose_request(OP_WRITE, REG_MODE, 8'h0c, 0, 0));
        send_request(compose_request(OP_REQUEST, REG_INIT, 8'h00, 3, 1));
        send_request(compose_request(OP_TICK, REG_INIT, 8'h00, 3, 0));
        send_request(compose_request(OP_REQUEST, REG_INIT, 8'h00, 3, 0));
        send_request(compose_request(OP_READ, REG_STATUS, 8'h00, 0, 0));
        send_request(compose_request(OP_WRITE, REG_INIT, 8'h03, 0, 0));
        send_request(compose_request(OP_READ, REG_MASK, 8'h00, 0, 0));
        send_request(compose_request(OP_WRITE, REG_STATUS, 8'hff, 0, 0));
        send_request(compose_request(OP_READ, REG_TEMP_LO, 8'h00, 0, 0));
    endtask

    // Hold the result side off long enough for the input to back up
    task automatic test_backpressure();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        hold_off_request = 60;
        repeat (40) send_request(33'({$urandom, $urandom}));
    endtask

    // Select a channel and load count, mode and mask, and at random address bytes and device control
    task automatic program_channel(input logic [1:0] ch);
        logic [7:0] wb;
        wb = 8'($urandom);
        wb[1:0] = ch;
        wb[2] = ($urandom_range(0, 3) == 0);
        send_request(compose_request(OP_WRITE, REG_CHAN, wb, $urandom, $urandom));
        send_request(compose_request(OP_WRITE, REG_COUNT_LO,
                                     ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3),
                                     $urandom, $urandom));
        send_request(compose_request(OP_WRITE, REG_COUNT_HI,
                                     ($urandom_range(0, 3) == 0) ? $urandom : 0,
                                     $urandom, $urandom));
        repeat ($urandom_range(0, 4))
        begin
            wb = ($urandom_range(0, 3) == 0) ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom);
            send_request(compose_request(OP_WRITE, REG_ADDR_0 + $urandom_range(0, 3), wb,
                                         $urandom, $urandom));
        end
        wb = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            wb[7:6] = 2'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0)
            wb[3:2] = 2'($urandom_range(1, 2));
        send_request(compose_request(OP_WRITE, REG_MODE, wb, $urandom, $urandom));
        wb = 8'($urandom);
        if ($urandom_range(0, 7) != 0)
            wb[ch] = 1'b0;
        send_request(compose_request(OP_WRITE, REG_MASK, wb, $urandom, $urandom));
        if ($urandom_range(0, 2) == 0)
        begin
            wb = 8'($urandom);
            if ($urandom_range(0, 3) != 0)
                wb[DEV_DISABLE_BIT] = 1'b0;
            send_request(compose_request(OP_WRITE, REG_DEV_LO, wb, $urandom, $urandom));
        end
        if ($urandom_range(0, 3) == 0)
            send_request(compose_request(OP_WRITE, REG_DEV_HI, $urandom, $urandom, $urandom));
    endtask

    // Mostly requests and ticks on the programmed channel, with reads and noise
    task automatic exercise_channel(input logic [1:0] ch, input int n);
        item_t req;
        int    pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            req = 33'({$urandom, $urandom});
            if (pick < 70)
            begin
                req.operation = (pick < 35) ? OP_REQUEST : OP_TICK;
                req.request_level = 1'b1;
                if ($urandom_range(0, 7) != 0)
                    req.chan = ch;
            end
            else if (pick < 78)
            begin
                req.operation = OP_REQUEST;
                req.request_level = 1'b0;
            end
            else if (pick < 90)
            begin
                req.operation = OP_READ;
                if ($urandom_range(0, 2) == 0)
                    req.reg_offset = REG_STATUS;
            end
            else if (pick < 96)
                req.operation = OP_WRITE;
            send_request(req);
        end
    endtask

    task automatic test_random_traffic(input int target, input bit allow_idles);
        logic [1:0] ch;
        ch = 2'($urandom);
        program_channel(ch);
        while (items_sent < target)
        begin
            sender_idles = allow_idles && ($urandom_range(0, 2) != 0);
            receiver_idles = allow_idles && ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 1) == 0)
            begin
                ch = 2'($urandom);
                program_channel(ch);
            end
            exercise_channel(ch, $urandom_range(4, 16));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        clear_dma_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_sequence();
        wait_for_results();
        test_backpressure();
        wait_for_results();
        test_random_traffic(1000, 1'b1);
        wait_for_results();
        test_random_traffic(1400, 1'b0);
        wait_for_results();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
